// ===== hdl/psrs_pkg.sv =====
// Shared constants, types and helpers of the per-thread shadow return stack.
`default_nettype none

package psrs_pkg;

   // Table geometry
   localparam int unsigned SLOTS       = 512;
   localparam int unsigned STACK_DEPTH = 16;
   localparam int unsigned PROBES      = 32;
   localparam int unsigned HASH_SHIFT  = 4;
   localparam int unsigned SP_OFFSET   = 8;

   localparam int unsigned SLOT_W  = $clog2(SLOTS);
   localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int unsigned FRAME_W = $clog2(SLOTS * STACK_DEPTH);
   localparam int unsigned PROBE_W = $clog2(PROBES + 1);

   // Request kinds
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_PUSH_LOST   = 2'd1,
      STATUS_POP_NO_SLOT = 2'd2,
      STATUS_POP_NO_FRAME = 2'd3
   } status_type;

   typedef struct packed {
      logic        func;
      logic [63:0] thread_id;
      logic [63:0] stack_pointer;
      logic [63:0] return_address;
      logic [31:0] hook_id;
      logic [63:0] timestamp;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] resume_address;
      logic [31:0] frame_hook;
      logic [63:0] elapsed_ticks;
      logic [63:0] lost_total;
   } rsp_type;

   typedef struct packed {
      logic [63:0]        owner;
      logic [DEPTH_W-1:0] depth;
   } slot_entry_type;

   typedef struct packed {
      logic [63:0] ret_addr;
      logic [63:0] sp;
      logic [31:0] hook;
      logic [63:0] stamp;
   } frame_entry_type;

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      slot_entry_type    wr_data;
   } slot_port_type;

   typedef struct packed {
      logic               rd_en;
      logic [FRAME_W-1:0] rd_addr;
      logic               wr_en;
      logic [FRAME_W-1:0] wr_addr;
      frame_entry_type    wr_data;
   } frame_port_type;

   typedef enum logic [1:0] {
      SUB_OWNER,
      SUB_SP,
      SUB_STAMP,
      SUB_LOST
   } sub_op_type;

   typedef struct packed {
      logic [63:0] diff;
      logic        zero;
      logic        eight;
   } sub_res_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SLOT_RD,
      ST_SLOT_CMP,
      ST_PUSH_WR,
      ST_LOST,
      ST_FRAME_RD,
      ST_FRAME_CMP,
      ST_ELAPSED
   } state_type;

   // Flat frame index of a slot's stack entry
   function automatic logic [FRAME_W-1:0] frame_addr(input logic [SLOT_W-1:0]  slot,
                                                     input logic [DEPTH_W-1:0] depth);
      frame_addr = FRAME_W'(slot) * FRAME_W'(STACK_DEPTH) + FRAME_W'(depth);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/psrs_sub.sv =====
// Shared 64-bit subtractor with operand selection and result flags.
`default_nettype none

module psrs_sub (
   input  wire psrs_pkg::sub_op_type      op,
   input  wire psrs_pkg::req_type         req,
   input  wire logic [63:0]               lost,
   input  wire psrs_pkg::slot_entry_type  slot_rd,
   input  wire psrs_pkg::frame_entry_type frame_rd,
   output psrs_pkg::sub_res_type          res
);

   logic [63:0] opa;
   logic [63:0] opb;
   logic [63:0] diff;

   // Pick operands: owner check, frame match, elapsed time, lost increment
   always_comb begin
      case (op)
         psrs_pkg::SUB_OWNER: begin
            opa = req.thread_id;
            opb = slot_rd.owner;
         end
         psrs_pkg::SUB_SP: begin
            opa = req.stack_pointer;
            opb = frame_rd.sp;
         end
         psrs_pkg::SUB_STAMP: begin
            opa = req.timestamp;
            opb = frame_rd.stamp;
         end
         psrs_pkg::SUB_LOST: begin
            // subtracting all ones adds one
            opa = lost;
            opb = '1;
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // Subtract and flag equal or one frame slot apart
   assign diff      = opa - opb;
   assign res.diff  = diff;
   assign res.zero  = (diff == '0);
   assign res.eight = (diff == 64'(psrs_pkg::SP_OFFSET));

endmodule

`default_nettype wire

// ===== hdl/psrs_slot_table.sv =====
// Slot table memory: owner thread and stack depth per slot.
`default_nettype none

module psrs_slot_table (
   input  wire logic                    clock,
   input  wire psrs_pkg::slot_port_type port,
   output psrs_pkg::slot_entry_type     rd_data
);

   psrs_pkg::slot_entry_type mem [psrs_pkg::SLOTS];
   psrs_pkg::slot_entry_type rd_data_ff;

   // Write one slot, read one slot with registered data
   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
      if (port.rd_en) begin
         rd_data_ff <= mem[port.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/psrs_frame_store.sv =====
// Frame store memory: recorded call frames of every slot's stack.
`default_nettype none

module psrs_frame_store (
   input  wire logic                     clock,
   input  wire psrs_pkg::frame_port_type port,
   output psrs_pkg::frame_entry_type     rd_data
);

   psrs_pkg::frame_entry_type mem [psrs_pkg::SLOTS * psrs_pkg::STACK_DEPTH];
   psrs_pkg::frame_entry_type rd_data_ff;

   // Write one frame, read one frame with registered data
   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
      if (port.rd_en) begin
         rd_data_ff <= mem[port.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/psrs_seq.sv =====
// Sequencer: slot probing, frame search and updates around the shared subtractor.
`default_nettype none

module psrs_seq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire psrs_pkg::req_type         req_data,
   output logic                           busy,
   output logic                           rsp_valid,
   output psrs_pkg::rsp_type              rsp_data,
   output psrs_pkg::slot_port_type        slot_port,
   input  wire psrs_pkg::slot_entry_type  slot_rd,
   output psrs_pkg::frame_port_type       frame_port,
   input  wire psrs_pkg::frame_entry_type frame_rd
);

   localparam logic [psrs_pkg::SLOT_W-1:0]  LAST_SLOT  = psrs_pkg::SLOT_W'(psrs_pkg::SLOTS - 1);
   localparam logic [psrs_pkg::PROBE_W-1:0] LAST_PROBE =
      psrs_pkg::PROBE_W'(psrs_pkg::PROBES - 1);
   localparam logic [psrs_pkg::DEPTH_W-1:0] FULL_DEPTH =
      psrs_pkg::DEPTH_W'(psrs_pkg::STACK_DEPTH);
   localparam logic [psrs_pkg::DEPTH_W-1:0] ONE_DEPTH = psrs_pkg::DEPTH_W'(1);

   psrs_pkg::state_type                 state_ff, state_in;
   psrs_pkg::req_type                   req_ff, req_in;
   psrs_pkg::rsp_type                   rsp_ff, rsp_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [63:0]                         lost_ff, lost_in;
   logic [psrs_pkg::SLOT_W-1:0]         clr_idx_ff, clr_idx_in;
   logic [psrs_pkg::SLOT_W-1:0]         slot_idx_ff, slot_idx_in;
   logic [psrs_pkg::PROBE_W-1:0]        probe_cnt_ff, probe_cnt_in;
   logic [psrs_pkg::DEPTH_W-1:0]        depth_ff, depth_in;

   psrs_pkg::sub_op_type                sub_op;
   psrs_pkg::sub_res_type               sub_res;

   logic                                is_push;
   logic                                owner_match;
   logic                                owner_free;
   logic                                slot_hit;
   logic [psrs_pkg::DEPTH_W-1:0]        eff_depth;
   logic [psrs_pkg::DEPTH_W-1:0]        depth_dn;
   logic [psrs_pkg::SLOT_W-1:0]         slot_nxt;
   logic                                start_zero_thread;

   psrs_sub u_sub (
      .op       (sub_op),
      .req      (req_ff),
      .lost     (lost_ff),
      .slot_rd  (slot_rd),
      .frame_rd (frame_rd),
      .res      (sub_res)
   );

   // Decode probe and search conditions
   assign is_push           = (req_ff.func == psrs_pkg::FUNC_PUSH);
   assign owner_match       = sub_res.zero;
   assign owner_free        = (slot_rd.owner == '0);
   assign slot_hit          = owner_match || (is_push && owner_free);
   assign eff_depth         = owner_match ? slot_rd.depth : '0;
   assign depth_dn          = depth_ff - ONE_DEPTH;
   assign slot_nxt          = (slot_idx_ff == LAST_SLOT) ? '0 : slot_idx_ff + 1'b1;
   assign start_zero_thread = (req_data.thread_id == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         psrs_pkg::ST_CLEAR: begin
            if (clr_idx_ff == LAST_SLOT) state_in = psrs_pkg::ST_IDLE;
         end
         psrs_pkg::ST_IDLE: begin
            if (start) begin
               if (!start_zero_thread) begin
                  state_in = psrs_pkg::ST_SLOT_RD;
               end else if (req_data.func == psrs_pkg::FUNC_PUSH) begin
                  state_in = psrs_pkg::ST_LOST;
               end
            end
         end
         psrs_pkg::ST_SLOT_RD: begin
            state_in = psrs_pkg::ST_SLOT_CMP;
         end
         psrs_pkg::ST_SLOT_CMP: begin
            if (slot_hit) begin
               if (is_push) begin
                  state_in = (eff_depth >= FULL_DEPTH) ? psrs_pkg::ST_LOST
                                                       : psrs_pkg::ST_PUSH_WR;
               end else begin
                  state_in = (slot_rd.depth == '0) ? psrs_pkg::ST_IDLE
                                                   : psrs_pkg::ST_FRAME_RD;
               end
            end else if (probe_cnt_ff == LAST_PROBE) begin
               state_in = is_push ? psrs_pkg::ST_LOST : psrs_pkg::ST_IDLE;
            end else begin
               state_in = psrs_pkg::ST_SLOT_RD;
            end
         end
         psrs_pkg::ST_PUSH_WR: begin
            state_in = psrs_pkg::ST_IDLE;
         end
         psrs_pkg::ST_LOST: begin
            state_in = psrs_pkg::ST_IDLE;
         end
         psrs_pkg::ST_FRAME_RD: begin
            state_in = psrs_pkg::ST_FRAME_CMP;
         end
         psrs_pkg::ST_FRAME_CMP: begin
            if (sub_res.eight) begin
               state_in = psrs_pkg::ST_ELAPSED;
            end else if (depth_ff == ONE_DEPTH) begin
               state_in = psrs_pkg::ST_IDLE;
            end else begin
               state_in = psrs_pkg::ST_FRAME_RD;
            end
         end
         psrs_pkg::ST_ELAPSED: begin
            state_in = psrs_pkg::ST_IDLE;
         end
         default: begin
            state_in = psrs_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs, memory ports and datapath updates
   always_comb begin
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      lost_in      = lost_ff;
      clr_idx_in   = clr_idx_ff;
      slot_idx_in  = slot_idx_ff;
      probe_cnt_in = probe_cnt_ff;
      depth_in     = depth_ff;
      sub_op       = psrs_pkg::SUB_OWNER;
      slot_port    = '0;
      frame_port   = '0;
      case (state_ff)
         psrs_pkg::ST_CLEAR: begin
            // sweep the slot table back to free
            slot_port.wr_en   = 1'b1;
            slot_port.wr_addr = clr_idx_ff;
            clr_idx_in        = clr_idx_ff + 1'b1;
         end
         psrs_pkg::ST_IDLE: begin
            if (start) begin
               req_in       = req_data;
               slot_idx_in  = req_data.thread_id[psrs_pkg::HASH_SHIFT +: psrs_pkg::SLOT_W];
               probe_cnt_in = '0;
               // reserved thread pops fail at once
               if (start_zero_thread && req_data.func == psrs_pkg::FUNC_POP) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.status         = psrs_pkg::STATUS_POP_NO_SLOT;
                  rsp_in.resume_address = '0;
                  rsp_in.frame_hook     = '0;
                  rsp_in.elapsed_ticks  = '0;
                  rsp_in.lost_total     = lost_ff;
               end
            end
         end
         psrs_pkg::ST_SLOT_RD: begin
            slot_port.rd_en   = 1'b1;
            slot_port.rd_addr = slot_idx_ff;
         end
         psrs_pkg::ST_SLOT_CMP: begin
            sub_op = psrs_pkg::SUB_OWNER;
            if (slot_hit) begin
               depth_in = eff_depth;
               if (!is_push && slot_rd.depth == '0) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.status         = psrs_pkg::STATUS_POP_NO_FRAME;
                  rsp_in.resume_address = '0;
                  rsp_in.frame_hook     = '0;
                  rsp_in.elapsed_ticks  = '0;
                  rsp_in.lost_total     = lost_ff;
               end
            end else if (probe_cnt_ff == LAST_PROBE) begin
               if (!is_push) begin
                  rsp_valid_in          = 1'b1;
                  rsp_in.status         = psrs_pkg::STATUS_POP_NO_SLOT;
                  rsp_in.resume_address = '0;
                  rsp_in.frame_hook     = '0;
                  rsp_in.elapsed_ticks  = '0;
                  rsp_in.lost_total     = lost_ff;
               end
            end else begin
               // advance to the next probe, wrapping round the table
               probe_cnt_in = probe_cnt_ff + 1'b1;
               slot_idx_in  = slot_nxt;
            end
         end
         psrs_pkg::ST_PUSH_WR: begin
            slot_port.wr_en          = 1'b1;
            slot_port.wr_addr        = slot_idx_ff;
            slot_port.wr_data.owner  = req_ff.thread_id;
            slot_port.wr_data.depth  = depth_ff + ONE_DEPTH;
            frame_port.wr_en         = 1'b1;
            frame_port.wr_addr       = psrs_pkg::frame_addr(slot_idx_ff, depth_ff);
            frame_port.wr_data.ret_addr = req_ff.return_address;
            frame_port.wr_data.sp    = req_ff.stack_pointer;
            frame_port.wr_data.hook  = req_ff.hook_id;
            frame_port.wr_data.stamp = req_ff.timestamp;
            rsp_valid_in             = 1'b1;
            rsp_in.status            = psrs_pkg::STATUS_OK;
            rsp_in.resume_address    = '0;
            rsp_in.frame_hook        = '0;
            rsp_in.elapsed_ticks     = '0;
            rsp_in.lost_total        = lost_ff;
         end
         psrs_pkg::ST_LOST: begin
            // count the dropped push
            sub_op                = psrs_pkg::SUB_LOST;
            lost_in               = sub_res.diff;
            rsp_valid_in          = 1'b1;
            rsp_in.status         = psrs_pkg::STATUS_PUSH_LOST;
            rsp_in.resume_address = '0;
            rsp_in.frame_hook     = '0;
            rsp_in.elapsed_ticks  = '0;
            rsp_in.lost_total     = sub_res.diff;
         end
         psrs_pkg::ST_FRAME_RD: begin
            frame_port.rd_en   = 1'b1;
            frame_port.rd_addr = psrs_pkg::frame_addr(slot_idx_ff, depth_dn);
         end
         psrs_pkg::ST_FRAME_CMP: begin
            // search downwards for the caller's frame
            sub_op   = psrs_pkg::SUB_SP;
            depth_in = depth_dn;
            if (!sub_res.eight && depth_ff == ONE_DEPTH) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = psrs_pkg::STATUS_POP_NO_FRAME;
               rsp_in.resume_address = '0;
               rsp_in.frame_hook     = '0;
               rsp_in.elapsed_ticks  = '0;
               rsp_in.lost_total     = lost_ff;
               depth_in              = depth_ff;
            end
         end
         psrs_pkg::ST_ELAPSED: begin
            // drop frames above the match, free the slot when empty
            sub_op                  = psrs_pkg::SUB_STAMP;
            slot_port.wr_en         = 1'b1;
            slot_port.wr_addr       = slot_idx_ff;
            slot_port.wr_data.owner = (depth_ff == '0) ? '0 : req_ff.thread_id;
            slot_port.wr_data.depth = depth_ff;
            rsp_valid_in            = 1'b1;
            rsp_in.status           = psrs_pkg::STATUS_OK;
            rsp_in.resume_address   = frame_rd.ret_addr;
            rsp_in.frame_hook       = frame_rd.hook;
            rsp_in.elapsed_ticks    = sub_res.diff;
            rsp_in.lost_total       = lost_ff;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psrs_pkg::ST_CLEAR;
         clr_idx_ff   <= '0;
         lost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      slot_idx_ff  <= slot_idx_in;
      probe_cnt_ff <= probe_cnt_in;
      depth_ff     <= depth_in;
   end

   assign busy      = (state_ff != psrs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/per_thread_shadow_return_stack_unit.sv =====
// Top level of the per-thread shadow return stack unit.
//
//  Channel  Ports                       Handshake
//  request  start, busy, req_data       beat taken when start high and busy low
//  result   rsp_valid, rsp_data         one-cycle strobe, one beat per request
//
// A push probes slots from its home slot, P being the slots probed (1..PROBES), then
// records its frame or is counted as lost; a pop probes the same way and then
// compares frames downwards from the top, F being the frames compared (1..STACK_DEPTH),
// answering with the match, with no slot or with no frame. Each probe and compare is a
// read plus a subtractor pass. A reserved-thread push is counted as lost at once.
// After reset all SLOTS (512) slot table entries are swept back to free with busy high;
// the receiver cannot stall and every result is a single-cycle strobe.
`default_nettype none

module per_thread_shadow_return_stack_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire psrs_pkg::req_type req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output psrs_pkg::rsp_type      rsp_data
);

   psrs_pkg::slot_port_type   slot_port;
   psrs_pkg::slot_entry_type  slot_rd;
   psrs_pkg::frame_port_type  frame_port;
   psrs_pkg::frame_entry_type frame_rd;

   psrs_slot_table u_slot_table (
      .clock   (clock),
      .port    (slot_port),
      .rd_data (slot_rd)
   );

   psrs_frame_store u_frame_store (
      .clock   (clock),
      .port    (frame_port),
      .rd_data (frame_rd)
   );

   psrs_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .slot_port  (slot_port),
      .slot_rd    (slot_rd),
      .frame_port (frame_port),
      .frame_rd   (frame_rd)
   );

   // An accepted beat keeps the unit busy or answers in the next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither in progress nor answered");

   // A frame is recorded only together with its slot update
   a_frame_with_slot: assert property (@(posedge clock) disable iff (reset)
      frame_port.wr_en |-> slot_port.wr_en)
      else $error("frame written without slot update");

   // Slot table is never read and written in the same cycle
   a_slot_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(slot_port.wr_en && slot_port.rd_en))
      else $error("slot table read and write collide");

endmodule

`default_nettype wire

// ===== tb/sv/per_thread_shadow_return_stack_unit_tb.sv =====
// Self-checking testbench for the per-thread shadow return stack unit.
`timescale 1ns / 100ps

module per_thread_shadow_return_stack_unit_tb;

   localparam int RANDOM_ITEMS   = 750;
   localparam int CREW_A         = 34;   // threads sharing one home slot
   localparam int CREW_B         = 6;    // threads homed on the last slot, probes wrap
   localparam int CREW           = CREW_A + CREW_B + 6;
   localparam int CROWD_HOME     = 5;
   localparam int QUIET_LO       = 300;
   localparam int QUIET_HI       = 450;
   localparam int DRAIN_CYCLES   = 120;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [63:0] ret;
      logic [63:0] sp;
      logic [31:0] hook;
      logic [63:0] stamp;
   } saved_frame_type;

   logic              clock;
   logic              reset    = 1'b1;
   logic              start    = 1'b0;
   psrs_pkg::req_type req_data = '0;
   logic              busy;
   logic              rsp_valid;
   psrs_pkg::rsp_type rsp_data;

   // Shadow copy of the unit's tables
   logic [63:0]     owner_of [psrs_pkg::SLOTS];
   int              depth_of [psrs_pkg::SLOTS];
   saved_frame_type saved_frames [psrs_pkg::SLOTS*psrs_pkg::STACK_DEPTH];
   logic [63:0]     lost_so_far;

   psrs_pkg::req_type stack_ops_q[$];
   psrs_pkg::rsp_type awaited_rsp_q[$];
   int          beats_in;
   int          mismatches;
   int          stall_cycles;
   int          push_count;
   int          pop_count;
   int          status_seen [4];

   // Stimulus bookkeeping: each thread's live stack pointers, bottom first
   logic [63:0] thr_id [CREW];
   logic [63:0] thr_sps [CREW][$];

   per_thread_shadow_return_stack_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Apply one call or return to the shadow tables and give the outcome
   function automatic psrs_pkg::rsp_type stack_outcome(psrs_pkg::req_type op);
      psrs_pkg::rsp_type r;
      int          home;
      int          slot;
      int          s;
      int          d;
      int          fi;
      bit          found;
      logic [63:0] wanted;
      r     = '0;
      slot  = -1;
      found = 1'b0;
      home  = int'((op.thread_id >> psrs_pkg::HASH_SHIFT) % 64'(psrs_pkg::SLOTS));
      // probe from the home slot; a push may claim the first free one
      if (op.thread_id != '0) begin
         for (int i = 0; i < psrs_pkg::PROBES && slot < 0; i++) begin
            s = (home + i) % psrs_pkg::SLOTS;
            if (owner_of[s] == op.thread_id) begin
               slot = s;
            end else if (op.func == psrs_pkg::FUNC_PUSH && owner_of[s] == '0) begin
               owner_of[s] = op.thread_id;
               depth_of[s] = 0;
               slot        = s;
            end
         end
      end
      if (op.func == psrs_pkg::FUNC_PUSH) begin
         push_count++;
         if (slot < 0 || depth_of[slot] >= psrs_pkg::STACK_DEPTH) begin
            lost_so_far++;
            r.status = psrs_pkg::STATUS_PUSH_LOST;
         end else begin
            fi = slot * psrs_pkg::STACK_DEPTH + depth_of[slot];
            saved_frames[fi] = '{op.return_address, op.stack_pointer, op.hook_id,
                                 op.timestamp};
            depth_of[slot]++;
         end
      end else begin
         pop_count++;
         if (slot < 0) begin
            r.status = psrs_pkg::STATUS_POP_NO_SLOT;
         end else begin
            // search from the top; abandoned frames above the match are dropped
            wanted = op.stack_pointer - 64'(psrs_pkg::SP_OFFSET);
            d      = depth_of[slot];
            while (d > 0 && !found) begin
               d--;
               fi = slot * psrs_pkg::STACK_DEPTH + d;
               if (saved_frames[fi].sp == wanted) begin
                  found            = 1'b1;
                  r.resume_address = saved_frames[fi].ret;
                  r.frame_hook     = saved_frames[fi].hook;
                  r.elapsed_ticks  = op.timestamp - saved_frames[fi].stamp;
                  depth_of[slot]   = d;
                  if (d == 0) owner_of[slot] = '0;
               end
            end
            if (!found) r.status = psrs_pkg::STATUS_POP_NO_FRAME;
         end
      end
      r.lost_total = lost_so_far;
      status_seen[r.status]++;
      return r;
   endfunction

   task automatic queue_op(input logic f, input logic [63:0] tid, input logic [63:0] sp,
                           input logic [63:0] ra, input logic [31:0] hk,
                           input logic [63:0] ts);
      psrs_pkg::req_type op;
      op = '{f, tid, sp, ra, hk, ts};
      stack_ops_q.push_back(op);
   endtask

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatches++;
      $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   // Driver: present queued beats, hold while busy, idle at random
   always @(posedge clock) begin : feed
      logic may_load;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            awaited_rsp_q.push_back(stack_outcome(req_data));
            beats_in++;
         end
         may_load = !start || !busy;
         if (may_load) begin
            if (stack_ops_q.size() != 0 &&
                !((beats_in < QUIET_LO || beats_in >= QUIET_HI) &&
                  $urandom_range(0, 99) < 24)) begin
               req_data <= stack_ops_q.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result strobe against the oldest expectation
   always @(posedge clock) begin : watch
      psrs_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_rsp_q.size() == 0) begin
            flag_mismatch("result with nothing awaited, status", 64'(rsp_data.status), '0);
         end else begin
            want = awaited_rsp_q.pop_front();
            if (rsp_data.status !== want.status)
               flag_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.resume_address !== want.resume_address)
               flag_mismatch("resume_address", rsp_data.resume_address, want.resume_address);
            if (rsp_data.frame_hook !== want.frame_hook)
               flag_mismatch("frame_hook", 64'(rsp_data.frame_hook), 64'(want.frame_hook));
            if (rsp_data.elapsed_ticks !== want.elapsed_ticks)
               flag_mismatch("elapsed_ticks", rsp_data.elapsed_ticks, want.elapsed_ticks);
            if (rsp_data.lost_total !== want.lost_total)
               flag_mismatch("lost_total", rsp_data.lost_total, want.lost_total);
         end
      end
   end

   // Watchdog: give up when no beat moves for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      logic [63:0] all_ones;
      logic [63:0] stamp;
      logic [63:0] sp;
      logic [63:0] tid;
      int          p;
      int          k;
      int          pick;
      int          depth_now;
      bit          do_pop;
      all_ones = '1;
      for (int s = 0; s < psrs_pkg::SLOTS; s++) begin
         owner_of[s] = '0;
         depth_of[s] = 0;
      end
      lost_so_far = '0;

      // Directed: reserved thread, missing slot, pointer wrap, stamp wrap
      queue_op(psrs_pkg::FUNC_PUSH, '0, 64'h100, all_ones, '1, 64'd10);
      queue_op(psrs_pkg::FUNC_POP, '0, 64'h108, '0, '0, 64'd11);
      queue_op(psrs_pkg::FUNC_POP, all_ones, 64'h108, '0, '0, 64'd12);
      queue_op(psrs_pkg::FUNC_PUSH, all_ones, 64'hFFFF_FFFF_FFFF_FFF8, all_ones, '1,
               all_ones);
      queue_op(psrs_pkg::FUNC_POP, all_ones, '0, '0, '0, 64'd3);
      queue_op(psrs_pkg::FUNC_POP, all_ones, '0, '0, '0, 64'd4);
      queue_op(psrs_pkg::FUNC_PUSH, all_ones, 64'h1000, '0, '0, '0);
      queue_op(psrs_pkg::FUNC_POP, all_ones, 64'h2000, all_ones, '1, 64'd20);
      // fill the stack, overflow it once, then unwind to the bottom frame
      for (int i = 1; i <= psrs_pkg::STACK_DEPTH; i++)
         queue_op(psrs_pkg::FUNC_PUSH, all_ones, 64'h1000 - 64'(16 * i), rand64(),
                  $urandom(), 64'(100 + i));
      queue_op(psrs_pkg::FUNC_POP, all_ones, 64'h1008, '0, '0, 64'd500);

      // Thread crews: a crowded home slot, a wrapping home slot, scattered ids
      for (int i = 0; i < CREW; i++) begin
         tid = rand64();
         if (i < CREW_A)
            tid[psrs_pkg::HASH_SHIFT +: psrs_pkg::SLOT_W] = psrs_pkg::SLOT_W'(CROWD_HOME);
         else if (i < CREW_A + CREW_B)
            tid[psrs_pkg::HASH_SHIFT +: psrs_pkg::SLOT_W] =
               psrs_pkg::SLOT_W'(psrs_pkg::SLOTS - 1);
         else tid[0] = 1'b1;
         thr_id[i] = tid;
      end

      // Random: nested call and return sequences, with some noise
      stamp = rand64();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         stamp += 64'($urandom_range(1, 300));
         if ($urandom_range(0, 19) == 0) stamp = rand64();
         if (n >= CREW_A && $urandom_range(0, 99) < 8) begin
            tid = ($urandom_range(0, 9) == 0) ? '0 : rand64();
            queue_op(1'($urandom_range(0, 1)), tid, rand64(), rand64(), $urandom(), stamp);
         end else begin
            // claim the whole crowded window first so later pushes find it full
            p         = (n < CREW_A) ? n : $urandom_range(0, CREW - 1);
            depth_now = thr_sps[p].size();
            if (depth_now == 0) do_pop = ($urandom_range(0, 99) < 15);
            else if (depth_now >= psrs_pkg::STACK_DEPTH) do_pop = ($urandom_range(0, 99) < 75);
            else do_pop = ($urandom_range(0, 99) < 45);
            if (n < CREW_A) do_pop = 1'b0;
            if (!do_pop) begin
               if (depth_now != 0) sp = thr_sps[p][depth_now - 1] -
                                        64'(8 * $urandom_range(2, 40));
               else sp = rand64() & ~64'h7;
               if (depth_now < psrs_pkg::STACK_DEPTH) thr_sps[p].push_back(sp);
               queue_op(psrs_pkg::FUNC_PUSH, thr_id[p], sp, rand64(), $urandom(), stamp);
            end else begin
               pick = $urandom_range(0, 99);
               if (depth_now != 0 && pick < 65) k = depth_now - 1;
               else if (depth_now != 0 && pick < 82) k = $urandom_range(0, depth_now - 1);
               else k = -1;
               if (k >= 0) begin
                  sp = thr_sps[p][k] + 64'(psrs_pkg::SP_OFFSET);
                  repeat (depth_now - k) void'(thr_sps[p].pop_back());
               end else begin
                  sp = rand64();
               end
               queue_op(psrs_pkg::FUNC_POP, thr_id[p], sp, rand64(), $urandom(), stamp);
            end
         end
      end

      // Drain: wait for every beat to be taken and answered
      while (stack_ops_q.size() != 0 || start || awaited_rsp_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("ran %0d requests: %0d pushes, %0d pops, %0d mismatches",
               beats_in, push_count, pop_count, mismatches);
      $display("outcomes: ok %0d, push lost %0d, pop without slot %0d, pop without frame %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
